@@ rtl/fifo_free_list_slot_allocator_core_assert.svh @@
// Assertion macros shared by the free-list slot allocator RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIFO_FREE_LIST_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define FIFO_FREE_LIST_SLOT_ALLOCATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define FSA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsa: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsa: next-cycle check failed");

`else

`define FSA_ASSERT_SAME(lbl, ante, cons)
`define FSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/fsa_pkg.sv @@
// Package for the free-list slot allocator: field widths, status codes,
// request kinds and the default pool size. No dependencies.
package fsa_pkg;

  // Default pool size
  localparam int SLOTS_DEF = 16;

  // Field widths
  localparam int KIND_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_HOLD    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

endpackage

@@ rtl/fifo_free_list_slot_allocator_core.sv @@
// Free-list slot allocator top level.
// Uses fsa_pkg, fsa_ram and the assertion macro header.
//
// Usage:
//   Input channel (in_*): one request per accepted beat. in_tuser is the
//   request kind (0 hold, 1 release); in_tdata[3:0] is the slot handle to
//   release, ignored for a hold.
//   Result channel (out_*): exactly one result per request, in order.
//   out_tuser is the status (0 reused, 1 new, 2 exhausted, 3 released,
//   4 release ignored); out_tdata[3:0] is the granted or released handle,
//   zero when none.
//   Latency: the result is valid in the cycle after the request is taken.
//   Throughput: one request per cycle unless stalled; the pool state and the
//   result register both update at the accepting edge, and the head of the
//   free queue is prefetched from the queue RAM so a reuse needs no wait.
//   Stall: a result waits in the output register; in_tready stays high
//   while that register is empty or being drained in the same cycle.
//   Reset: synchronous; the pool is empty, no slot is created or held and
//   the output register is empty. The queue RAM needs no clearing pass.
module fifo_free_list_slot_allocator_core #(
  parameter int SLOTS = fsa_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fsa_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] slot_in, rest zero
  input  logic [fsa_pkg::KIND_W-1:0]       in_tuser,   // [0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fsa_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [3:0] slot_out, rest zero
  output logic [fsa_pkg::STATUS_W-1:0]     out_tuser   // [2:0] status
);

  import fsa_pkg::*;

`include "fifo_free_list_slot_allocator_core_assert.svh"

  // Index, count and comparison widths
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int OW = (IW > SLOT_W) ? IW : SLOT_W;

  // Pool state
  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    free_count_r, free_count_nxt;
  logic [CW-1:0]    created_count_r, created_count_nxt;
  logic [SLOTS-1:0] held_mask_r, held_mask_nxt;

  // Head prefetch bypass
  logic             byp_hit_r;
  logic [IW-1:0]    byp_data_r;
  logic [IW-1:0]    ram_rd_data;
  logic [IW-1:0]    head_data;

  // Result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  // Request decode
  logic              in_fire;
  logic [SLOT_W-1:0] req_slot;
  logic [XW-1:0]     req_slot_x;
  logic [IW-1:0]     req_idx;
  logic              rel_ok;
  logic              can_reuse;
  logic              can_create;
  logic              q_wr_en;
  logic [IW-1:0]     grant_slot;
  logic [OW-1:0]     grant_wide;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign req_slot   = in_tdata[SLOT_W-1:0];
  assign req_slot_x = XW'(req_slot);
  assign req_idx    = req_slot_x[IW-1:0];

  // Head of the free queue: RAM read data unless written the same edge
  assign head_data = byp_hit_r ? byp_data_r : ram_rd_data;

  assign can_reuse  = (free_count_r != '0);
  assign can_create = (created_count_r < CW'(SLOTS));
  assign rel_ok     = (req_slot_x < XW'(created_count_r)) && held_mask_r[req_idx];
  assign q_wr_en    = in_fire && (in_tuser == KIND_RELEASE) && rel_ok;

  // Decide the request and compute the next pool state
  always_comb begin
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    free_count_nxt    = free_count_r;
    created_count_nxt = created_count_r;
    held_mask_nxt     = held_mask_r;
    out_status_nxt    = ST_IGNORED;
    grant_slot        = '0;
    if (in_tuser == KIND_HOLD) begin
      if (can_reuse) begin
        grant_slot     = head_data;
        out_status_nxt = ST_REUSED;
        head_nxt       = (head_r == IW'(SLOTS - 1)) ? '0 : head_r + 1'b1;
        free_count_nxt = free_count_r - 1'b1;
        held_mask_nxt[head_data] = 1'b1;
      end else if (can_create) begin
        grant_slot        = created_count_r[IW-1:0];
        out_status_nxt    = ST_NEW;
        created_count_nxt = created_count_r + 1'b1;
        held_mask_nxt[created_count_r[IW-1:0]] = 1'b1;
      end else begin
        out_status_nxt = ST_EXHAUSTED;
      end
    end else if (rel_ok) begin
      grant_slot     = req_idx;
      out_status_nxt = ST_RELEASED;
      tail_nxt       = (tail_r == IW'(SLOTS - 1)) ? '0 : tail_r + 1'b1;
      free_count_nxt = free_count_r + 1'b1;
      held_mask_nxt[req_idx] = 1'b0;
    end
    grant_wide   = OW'(grant_slot);
    out_slot_nxt = grant_wide[SLOT_W-1:0];
  end

  // Free queue storage; read address tracks the head after this edge
  fsa_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (tail_r),
    .wr_data (req_idx),
    .rd_addr (in_fire ? head_nxt : head_r),
    .rd_data (ram_rd_data)
  );

  // Advance pool state on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r          <= '0;
      tail_r          <= '0;
      free_count_r    <= '0;
      created_count_r <= '0;
      held_mask_r     <= '0;
    end else if (in_fire) begin
      head_r          <= head_nxt;
      tail_r          <= tail_nxt;
      free_count_r    <= free_count_nxt;
      created_count_r <= created_count_nxt;
      held_mask_r     <= held_mask_nxt;
    end
  end

  // Capture a queue write that lands on the address being prefetched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= q_wr_en && (tail_r == (in_fire ? head_nxt : head_r));
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= req_idx;
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'(out_slot_r);

  // Free slots plus held slots account for every created slot
  `FSA_ASSERT_SAME(a_pool_conserved, 1'b1, (32'(free_count_r) + 32'($countones(held_mask_r))) == 32'(created_count_r))

  // The pool never grows past its size
  `FSA_ASSERT_SAME(a_created_bound, 1'b1, created_count_r <= CW'(SLOTS))

  // An exhausted hold leaves the pool untouched
  `FSA_ASSERT_NEXT(a_exhausted_stable, in_fire && (in_tuser == KIND_HOLD) && !can_reuse && !can_create, $stable(created_count_r) && $stable(free_count_r) && $stable(held_mask_r))

  // A good release queues exactly one more free slot
  `FSA_ASSERT_NEXT(a_release_queues, q_wr_en, free_count_r == $past(free_count_r) + 1'b1)

  // Every accepted request yields a result in the next cycle
  `FSA_ASSERT_NEXT(a_result_follows, in_fire, out_valid_r)

endmodule

@@ rtl/fsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module fsa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
